>>> src/grid_overlay_pixel_blend_defines.svh
// assertion macros for the grid overlay pixel blender
// used by the top level only, expects aclk and aresetn in scope
`ifndef GRID_OVERLAY_PIXEL_BLEND_DEFINES_SVH
`define GRID_OVERLAY_PIXEL_BLEND_DEFINES_SVH

// same-cycle implication, off while in reset
`define GOPB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, active during reset as well
`define GOPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/gopb_pkg.sv
// shared types, constants and helpers for the grid overlay pixel blender
// no dependencies
`default_nettype none

package gopb_pkg;

    localparam int CFG_BITS   = 14;
    localparam int COLOR_BITS = 32;
    localparam int PIX_BITS   = 8;
    localparam int CFG_IDX_BITS = 3;
    localparam int OFFSET_MAG_BITS = 13;

    localparam logic [PIX_BITS-1:0] PIX_MAX = 8'hFF;
    // a period register of zero acts as one more than the largest value
    localparam logic [CFG_BITS:0] ZERO_PERIOD = 15'h4000;

    // register reset values
    localparam logic [CFG_BITS-1:0]   RST_OFFSET    = 14'd0;
    localparam logic [CFG_BITS-1:0]   RST_CELL      = 14'd1;
    localparam logic [CFG_BITS-1:0]   RST_THICKNESS = 14'd1;
    localparam logic [COLOR_BITS-1:0] RST_COLOR     = 32'hFF8080FF;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_OFFSET_X,
        REG_OFFSET_Y,
        REG_CELL_WIDTH,
        REG_CELL_HEIGHT,
        REG_LINE_THICKNESS,
        REG_INVERT_MODE,
        REG_GRID_COLOR
    } gopb_reg_idx_t;

    typedef struct packed {
        logic signed [CFG_BITS-1:0] offset_x;
        logic signed [CFG_BITS-1:0] offset_y;
        logic [CFG_BITS-1:0]        cell_width;
        logic [CFG_BITS-1:0]        cell_height;
        logic [CFG_BITS-1:0]        line_thickness;
        logic                       invert_mode;
        logic [COLOR_BITS-1:0]      grid_color;
    } gopb_cfg_t;

    // settings of one grid axis
    typedef struct packed {
        logic signed [CFG_BITS-1:0] offset;
        logic [CFG_BITS-1:0]        period;
        logic [CFG_BITS-1:0]        thickness;
    } gopb_axis_cfg_t;

    // magnitude width of (coordinate - offset)
    function automatic int diff_bits(input int coord_bits);
        return ((coord_bits > OFFSET_MAG_BITS) ? coord_bits : OFFSET_MAG_BITS) + 1;
    endfunction

endpackage

`default_nettype wire

>>> src/gopb_axis.sv
// per-axis grid hit test: floored modulo by the cell period, one bit per stage
// depends on gopb_pkg
`default_nettype none

module gopb_axis
    import gopb_pkg::*;
#(
    parameter int COORD_BITS = 13,
    localparam int DIFF_BITS = diff_bits(COORD_BITS),
    localparam int STAGES    = DIFF_BITS + 3
) (
    input  wire logic                  aclk,
    input  wire logic [STAGES-1:0]     stage_en,
    input  wire logic [COORD_BITS-1:0] coord,
    input  wire gopb_axis_cfg_t        axis_cfg,
    output logic                       hit
);

    logic [CFG_BITS:0]      period;
    logic [DIFF_BITS:0]     pos_ext;
    logic [DIFF_BITS:0]     off_ext;
    logic [DIFF_BITS:0]     diff;
    logic [DIFF_BITS:0]     diff_abs;

    logic [DIFF_BITS-1:0]   mag_reg [0:DIFF_BITS];
    logic                   neg_reg [0:DIFF_BITS];
    logic [CFG_BITS:0]      rem_reg [1:DIFF_BITS];
    logic [CFG_BITS:0]      mod_reg;
    logic [CFG_BITS:0]      mod_next;
    logic                   hit_reg;

    // effective period
    assign period = (axis_cfg.period == '0) ? ZERO_PERIOD : {1'b0, axis_cfg.period};

    // signed difference and its magnitude
    assign pos_ext  = {{(DIFF_BITS + 1 - COORD_BITS){1'b0}}, coord};
    assign off_ext  = {{(DIFF_BITS + 1 - CFG_BITS){axis_cfg.offset[CFG_BITS-1]}},
                       axis_cfg.offset};
    assign diff     = pos_ext - off_ext;
    assign diff_abs = diff[DIFF_BITS] ? (~diff + 1'b1) : diff;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            mag_reg[0] <= diff_abs[DIFF_BITS-1:0];
            neg_reg[0] <= diff[DIFF_BITS];
        end
    end

    // restoring remainder, one dividend bit per stage
    for (genvar j = 1; j <= DIFF_BITS; j++) begin : g_rem
        logic [CFG_BITS:0]   rem_prev;
        logic [CFG_BITS+1:0] trial;
        logic [CFG_BITS+1:0] trial_sub;
        logic [CFG_BITS:0]   rem_next;

        if (j == 1) begin : g_first
            assign rem_prev = '0;
        end else begin : g_rest
            assign rem_prev = rem_reg[j-1];
        end

        assign trial     = {rem_prev, mag_reg[j-1][DIFF_BITS-1]};
        assign trial_sub = trial - {1'b0, period};
        assign rem_next  = (trial >= {1'b0, period}) ? trial_sub[CFG_BITS:0]
                                                     : trial[CFG_BITS:0];

        always_ff @(posedge aclk) begin
            if (stage_en[j]) begin
                rem_reg[j] <= rem_next;
                mag_reg[j] <= {mag_reg[j-1][DIFF_BITS-2:0], 1'b0};
                neg_reg[j] <= neg_reg[j-1];
            end
        end
    end

    // fold a negative remainder back into [0, period)
    assign mod_next = (neg_reg[DIFF_BITS] && rem_reg[DIFF_BITS] != '0)
                    ? (period - rem_reg[DIFF_BITS]) : rem_reg[DIFF_BITS];

    always_ff @(posedge aclk) begin
        if (stage_en[DIFF_BITS+1]) begin
            mod_reg <= mod_next;
        end
        if (stage_en[DIFF_BITS+2]) begin
            hit_reg <= (mod_reg < {1'b0, axis_cfg.thickness});
        end
    end

    assign hit = hit_reg;

endmodule

`default_nettype wire

>>> src/gopb_blend.sv
// two-stage colour blend or luma invert of a pixel on the grid
// depends on gopb_pkg
`default_nettype none

module gopb_blend
    import gopb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic [1:0]            stage_en,
    input  wire logic                  hit_x,
    input  wire logic                  hit_y,
    input  wire logic [3*PIX_BITS-1:0] samples,   // luma, cb, cr from bit 0 up
    input  wire gopb_cfg_t             cfg,
    output logic [3*PIX_BITS-1:0]      pix_out,   // luma, cb, cr from bit 0 up
    output logic                       on_grid
);

    logic [PIX_BITS-1:0]   alpha;
    logic [PIX_BITS-1:0]   alpha_inv;

    logic                  hit_reg;
    logic [3*PIX_BITS-1:0] samp_reg;
    logic [2*PIX_BITS-1:0] prod_p_reg [0:2];
    logic [2*PIX_BITS-1:0] prod_c_reg [0:2];

    logic [3*PIX_BITS-1:0] mixed;
    logic [3*PIX_BITS-1:0] pix_next;
    logic [3*PIX_BITS-1:0] pix_reg;
    logic                  on_grid_reg;

    assign alpha     = cfg.grid_color[PIX_BITS-1:0];
    assign alpha_inv = PIX_MAX - alpha;

    // stage a: weighted products per component
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            hit_reg  <= hit_x | hit_y;
            samp_reg <= samples;
            for (int i = 0; i < 3; i++) begin
                prod_p_reg[i] <= samples[PIX_BITS*i +: PIX_BITS] * alpha_inv;
                prod_c_reg[i] <= cfg.grid_color[COLOR_BITS-1-PIX_BITS*i -: PIX_BITS] * alpha;
            end
        end
    end

    // stage b: sum, exact divide by 255 for sums below 65280
    for (genvar i = 0; i < 3; i++) begin : g_div
        logic [2*PIX_BITS-1:0] sum;
        logic [2*PIX_BITS-1:0] quo;

        assign sum = prod_p_reg[i] + prod_c_reg[i];
        assign quo = sum + {{PIX_BITS{1'b0}}, sum[2*PIX_BITS-1:PIX_BITS]} + 1'b1;
        assign mixed[PIX_BITS*i +: PIX_BITS] = quo[2*PIX_BITS-1:PIX_BITS];
    end

    // pick pass, invert or blend
    always_comb begin
        if (!hit_reg) begin
            pix_next = samp_reg;
        end else if (cfg.invert_mode) begin
            pix_next = {samp_reg[3*PIX_BITS-1:PIX_BITS], ~samp_reg[PIX_BITS-1:0]};
        end else begin
            pix_next = mixed;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            pix_reg     <= pix_next;
            on_grid_reg <= hit_reg;
        end
    end

    assign pix_out = pix_reg;
    assign on_grid = on_grid_reg;

endmodule

`default_nettype wire

>>> src/grid_overlay_pixel_blend.sv
// Grid overlay pixel blender, top level.
// The modulo by the cell period takes one stage per bit of |coordinate - offset|.
// Throughput: one pixel per cycle while m_tready is high; a full stage holds when the next one holds.
// Reset (aresetn low, synchronous) empties the pipeline and loads default config.
// depends on gopb_pkg, gopb_axis, gopb_blend, grid_overlay_pixel_blend_defines.svh
`default_nettype none
`include "grid_overlay_pixel_blend_defines.svh"

module grid_overlay_pixel_blend
    import gopb_pkg::*;
#(
    parameter int COORD_BITS = 13,
    localparam int S_TDATA_W = ((2 * COORD_BITS + 3 * PIX_BITS + 7) / 8) * 8
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    // pixel input
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // pixel_col, pixel_row, luma_in, cb_in, cr_in from bit 0 up, zero padded
    input  wire logic [S_TDATA_W-1:0]    s_tdata,

    // pixel output
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [3*PIX_BITS-1:0]        m_tdata,   // luma_out, cb_out, cr_out from bit 0 up
    output logic                         m_tuser,   // on_grid

    // configuration writes
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [COLOR_BITS-1:0]   cfg_data
);

    localparam int DIFF_BITS = diff_bits(COORD_BITS);
    localparam int AX_STAGES = DIFF_BITS + 3;
    localparam int NS        = AX_STAGES + 2;

    gopb_cfg_t             cfg_reg;
    gopb_axis_cfg_t        axis_x_cfg;
    gopb_axis_cfg_t        axis_y_cfg;

    logic [NS:0]           stage_en;
    logic [NS-1:0]         valid_reg;
    logic [NS-1:0]         valid_next;
    logic [3*PIX_BITS-1:0] samp_reg [0:AX_STAGES-1];

    logic                  hit_x;
    logic                  hit_y;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offset_x       <= RST_OFFSET;
            cfg_reg.offset_y       <= RST_OFFSET;
            cfg_reg.cell_width     <= RST_CELL;
            cfg_reg.cell_height    <= RST_CELL;
            cfg_reg.line_thickness <= RST_THICKNESS;
            cfg_reg.invert_mode    <= 1'b0;
            cfg_reg.grid_color     <= RST_COLOR;
        end else if (cfg_valid) begin
            case (gopb_reg_idx_t'(cfg_index))
                REG_OFFSET_X:       cfg_reg.offset_x       <= cfg_data[CFG_BITS-1:0];
                REG_OFFSET_Y:       cfg_reg.offset_y       <= cfg_data[CFG_BITS-1:0];
                REG_CELL_WIDTH:     cfg_reg.cell_width     <= cfg_data[CFG_BITS-1:0];
                REG_CELL_HEIGHT:    cfg_reg.cell_height    <= cfg_data[CFG_BITS-1:0];
                REG_LINE_THICKNESS: cfg_reg.line_thickness <= cfg_data[CFG_BITS-1:0];
                REG_INVERT_MODE:    cfg_reg.invert_mode    <= cfg_data[0];
                REG_GRID_COLOR:     cfg_reg.grid_color     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign axis_x_cfg = '{offset: cfg_reg.offset_x, period: cfg_reg.cell_width,
                          thickness: cfg_reg.line_thickness};
    assign axis_y_cfg = '{offset: cfg_reg.offset_y, period: cfg_reg.cell_height,
                          thickness: cfg_reg.line_thickness};

    // per-stage advance: a stage moves when empty or when the next one moves
    assign stage_en[NS] = m_tready;
    for (genvar k = 0; k < NS; k++) begin : g_en
        assign stage_en[k] = !valid_reg[k] || stage_en[k+1];
    end

    assign s_tready   = stage_en[0];
    assign valid_next = {valid_reg[NS-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    // samples ride alongside the hit test
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            samp_reg[0] <= s_tdata[2*COORD_BITS +: 3*PIX_BITS];
        end
        for (int k = 1; k < AX_STAGES; k++) begin
            if (stage_en[k]) begin
                samp_reg[k] <= samp_reg[k-1];
            end
        end
    end

    gopb_axis #(
        .COORD_BITS (COORD_BITS)
    ) u_axis_x (
        .aclk     (aclk),
        .stage_en (stage_en[AX_STAGES-1:0]),
        .coord    (s_tdata[COORD_BITS-1:0]),
        .axis_cfg (axis_x_cfg),
        .hit      (hit_x)
    );

    gopb_axis #(
        .COORD_BITS (COORD_BITS)
    ) u_axis_y (
        .aclk     (aclk),
        .stage_en (stage_en[AX_STAGES-1:0]),
        .coord    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .axis_cfg (axis_y_cfg),
        .hit      (hit_y)
    );

    gopb_blend u_blend (
        .aclk     (aclk),
        .stage_en (stage_en[NS-1:NS-2]),
        .hit_x    (hit_x),
        .hit_y    (hit_y),
        .samples  (samp_reg[AX_STAGES-1]),
        .cfg      (cfg_reg),
        .pix_out  (m_tdata),
        .on_grid  (m_tuser)
    );

    assign m_tvalid = valid_reg[NS-1];

    // checks
    `GOPB_ASSERT_NOW(a_full_stall, (&valid_reg) && !m_tready, !s_tready, "full pipeline took a word")
    `GOPB_ASSERT_NOW(a_no_thickness, m_tvalid && cfg_reg.line_thickness == '0, !m_tuser, "grid hit with zero thickness")
    `GOPB_ASSERT_NEXT(a_reset_empty, !aresetn, valid_reg == '0, "pipeline not empty after reset")

endmodule

`default_nettype wire
